// ----- rtl/mbet_pkg.sv -----
// Shared types and constants for the Mandelbrot escape-time block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mbet_pkg;

    localparam int CNT_WIDTH = 16;
    localparam logic [CNT_WIDTH-1:0] MAX_ITER_RESET = 16'd255;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

    localparam int NUM_PROD = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_SUM,
        ST_TEST,
        ST_FINISH
    } core_state_t;

endpackage

`default_nettype wire

// ----- rtl/mbet_point_queue.sv -----
// Front end: accepts points and holds them in a short queue for the core.
// Depends on mbet_pkg for the queue depth and pointer widths.
`timescale 1ns / 1ps
`default_nettype none

module mbet_point_queue #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       full,
    input  wire logic [DATA_WIDTH-1:0] push_data,
    input  wire logic                  pop,
    output logic                       not_empty,
    output logic [DATA_WIDTH-1:0]      head_data
);
    import mbet_pkg::*;

    logic [DATA_WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QFILL_W-1:0]    fill_reg;
    logic [QFILL_W-1:0]    fill_next;
    logic                  push;

    assign full      = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];
    assign push      = push_valid && !full;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + QFILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QFILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QFILL_W'(QUEUE_DEPTH))
        else $error("queue fill exceeds depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("pop from empty queue");

    a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> fill_reg == $past(fill_reg) + QFILL_W'(1))
        else $error("fill count lost a transfer");

endmodule

`default_nettype wire

// ----- rtl/mbet_iter_core.sv -----
// Back end: iterates z = z*z + c for one point at a time and holds the result.
// Depends on mbet_pkg for the state type and counter width.
`timescale 1ns / 1ps
`default_nettype none

module mbet_iter_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [mbet_pkg::CNT_WIDTH-1:0]  max_iterations,
    input  wire logic                            q_not_empty,
    input  wire logic [2*COORD_WIDTH-1:0]        q_head,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [mbet_pkg::CNT_WIDTH-1:0]       escape_count,
    output logic                                 in_set
);
    import mbet_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int H     = (W + 1) / 2;
    localparam int HI    = W - H;
    localparam int PRODW = 2 * W;
    localparam int SW    = PRODW + 1;
    localparam int EW    = (2 * FRAC_BITS + 3 > PRODW + 1) ? 2 * FRAC_BITS + 3 : PRODW + 1;
    localparam logic [EW-1:0] ESC_LIMIT = EW'(1) << (2 * FRAC_BITS + 2);

    localparam int LN_RR = 0;
    localparam int LN_II = 1;
    localparam int LN_RI = 2;

    core_state_t state_reg;
    core_state_t state_next;

    logic signed [W-1:0] c_r_reg, c_r_next;
    logic signed [W-1:0] c_i_reg, c_i_next;
    logic signed [W-1:0] zr_reg, zr_next;
    logic signed [W-1:0] zi_reg, zi_next;
    logic [CNT_WIDTH-1:0] count_reg, count_next;
    logic [CNT_WIDTH-1:0] count_inc;
    logic hit_limit_reg, hit_limit_next;

    logic out_valid_reg, out_valid_next;
    logic [CNT_WIDTH-1:0] escape_count_reg, escape_count_next;
    logic in_set_reg, in_set_next;

    logic signed [W-1:0] op_a [NUM_PROD];
    logic signed [W-1:0] op_b [NUM_PROD];
    logic [W-1:0]        a_mag [NUM_PROD];
    logic [W-1:0]        b_mag [NUM_PROD];

    logic [2*H-1:0]  pp00_reg [NUM_PROD];
    logic [2*H-1:0]  pp00_next [NUM_PROD];
    logic [W-1:0]    pp01_reg [NUM_PROD];
    logic [W-1:0]    pp01_next [NUM_PROD];
    logic [W-1:0]    pp10_reg [NUM_PROD];
    logic [W-1:0]    pp10_next [NUM_PROD];
    logic [2*HI-1:0] pp11_reg [NUM_PROD];
    logic [2*HI-1:0] pp11_next [NUM_PROD];
    logic            neg_reg [NUM_PROD];
    logic            neg_next [NUM_PROD];

    logic [PRODW-1:0]        mag_full [NUM_PROD];
    logic signed [PRODW-1:0] prod_reg [NUM_PROD];
    logic signed [PRODW-1:0] prod_next [NUM_PROD];

    logic [EW-1:0]           sq_sum;
    logic                    escaped;
    logic signed [PRODW-1:0] re_diff;
    logic signed [PRODW-1:0] re_sh;
    logic signed [PRODW-1:0] im_sh;
    logic signed [SW-1:0]    zr_wide;
    logic signed [SW-1:0]    zi_wide;
    logic signed [W-1:0]     zr_sat;
    logic signed [W-1:0]     zi_sat;

    function automatic logic [W-1:0] magnitude(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic signed [W-1:0] saturate(input logic signed [SW-1:0] v);
        logic [SW-W:0] top_bits;
        top_bits = v[SW-1:W-1];
        if ((&top_bits) || !(|top_bits))
        begin
            return v[W-1:0];
        end
        return v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    assign op_a[LN_RR] = zr_reg;
    assign op_b[LN_RR] = zr_reg;
    assign op_a[LN_II] = zi_reg;
    assign op_b[LN_II] = zi_reg;
    assign op_a[LN_RI] = zr_reg;
    assign op_b[LN_RI] = zi_reg;

    // split magnitudes into halves so each multiplier stays narrow
    always_comb
    begin
        for (int i = 0; i < NUM_PROD; i++)
        begin
            a_mag[i]     = magnitude(op_a[i]);
            b_mag[i]     = magnitude(op_b[i]);
            pp00_next[i] = a_mag[i][H-1:0] * b_mag[i][H-1:0];
            pp01_next[i] = a_mag[i][H-1:0] * b_mag[i][W-1:H];
            pp10_next[i] = a_mag[i][W-1:H] * b_mag[i][H-1:0];
            pp11_next[i] = a_mag[i][W-1:H] * b_mag[i][W-1:H];
            neg_next[i]  = op_a[i][W-1] ^ op_b[i][W-1];
        end
    end

    // assemble full products and apply sign
    always_comb
    begin
        for (int i = 0; i < NUM_PROD; i++)
        begin
            mag_full[i] = (PRODW'(pp11_reg[i]) << (2 * H))
                        + ((PRODW'(pp01_reg[i]) + PRODW'(pp10_reg[i])) << H)
                        + PRODW'(pp00_reg[i]);
            prod_next[i] = neg_reg[i] ? $signed(-mag_full[i]) : $signed(mag_full[i]);
        end
    end

    // escape test and next z
    always_comb
    begin
        sq_sum  = EW'($unsigned(prod_reg[LN_RR])) + EW'($unsigned(prod_reg[LN_II]));
        escaped = (sq_sum >= ESC_LIMIT);
        re_diff = prod_reg[LN_RR] - prod_reg[LN_II];
        re_sh   = re_diff >>> FRAC_BITS;
        im_sh   = prod_reg[LN_RI] >>> (FRAC_BITS - 1);
        zr_wide = SW'(re_sh) + SW'(c_r_reg);
        zi_wide = SW'(im_sh) + SW'(c_i_reg);
        zr_sat  = saturate(zr_wide);
        zi_sat  = saturate(zi_wide);
    end

    assign count_inc = count_reg + CNT_WIDTH'(1);

    always_comb
    begin
        state_next        = state_reg;
        c_r_next          = c_r_reg;
        c_i_next          = c_i_reg;
        zr_next           = zr_reg;
        zi_next           = zi_reg;
        count_next        = count_reg;
        hit_limit_next    = hit_limit_reg;
        out_valid_next    = out_valid_reg && out_stall;
        escape_count_next = escape_count_reg;
        in_set_next       = in_set_reg;
        q_pop             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    c_r_next   = $signed(q_head[2*W-1:W]);
                    c_i_next   = $signed(q_head[W-1:0]);
                    zr_next    = '0;
                    zi_next    = '0;
                    count_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (count_reg < max_iterations)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    hit_limit_next = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (escaped)
                begin
                    hit_limit_next = 1'b0;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    zr_next    = zr_sat;
                    zi_next    = zi_sat;
                    count_next = count_inc;
                    if (count_inc < max_iterations)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        hit_limit_next = 1'b1;
                        state_next     = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    in_set_next       = hit_limit_reg;
                    escape_count_next = hit_limit_reg ? '0 : count_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_r_reg          <= c_r_next;
        c_i_reg          <= c_i_next;
        zr_reg           <= zr_next;
        zi_reg           <= zi_next;
        count_reg        <= count_next;
        hit_limit_reg    <= hit_limit_next;
        escape_count_reg <= escape_count_next;
        in_set_reg       <= in_set_next;
        for (int i = 0; i < NUM_PROD; i++)
        begin
            if (state_reg == ST_MUL)
            begin
                pp00_reg[i] <= pp00_next[i];
                pp01_reg[i] <= pp01_next[i];
                pp10_reg[i] <= pp10_next[i];
                pp11_reg[i] <= pp11_next[i];
                neg_reg[i]  <= neg_next[i];
            end
            if (state_reg == ST_SUM)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign escape_count = escape_count_reg;
    assign in_set       = in_set_reg;

    a_in_set_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && in_set_reg) |-> escape_count_reg == '0)
        else $error("in-set result with nonzero count");

    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result loaded outside finish state");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_TEST && state_reg == ST_MUL)
            |-> count_reg == $past(count_reg) + CNT_WIDTH'(1))
        else $error("iteration count did not advance by one");

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time unit: one signed fixed-point point c in, one escape
// count out. A two-entry input queue feeds an iteration core with an output
// register, so a new point is taken while a result waits. Each step of
// z = z*z + c runs through the partial-product, product-assembly and
// escape-test-and-update states. Taking the point, the limit check and
// handing the result to the output register, which waits while the output
// stalls, come on top. The sustained rate is therefore set by the iteration
// count and by any output stall. Depends on mbet_pkg, mbet_point_queue and
// mbet_iter_core.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [mbet_pkg::CNT_WIDTH-1:0] cfg_write_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]  c_real,
    input  wire logic signed [COORD_WIDTH-1:0]  c_imag,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [mbet_pkg::CNT_WIDTH-1:0]      escape_count,
    output logic                                in_set
);
    import mbet_pkg::*;

    logic [CNT_WIDTH-1:0]     max_iter_reg;
    logic                     q_not_empty;
    logic                     q_pop;
    logic [2*COORD_WIDTH-1:0] q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (cfg_write_en)
        begin
            max_iter_reg <= cfg_write_data;
        end
    end

    mbet_point_queue #(
        .DATA_WIDTH (2 * COORD_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .full       (in_stall),
        .push_data  ({c_real, c_imag}),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_data  (q_head)
    );

    mbet_iter_core #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_iterations (max_iter_reg),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .escape_count   (escape_count),
        .in_set         (in_set)
    );

endmodule

`default_nettype wire
